### design/dpd_pkg.sv
// Shared types and codes for the double-ended queue block.
// Request and result payloads, operation codes and status codes.
// No dependencies.
package dpd_pkg;

  // Raw operation codes on the request port.
  localparam logic [2:0] FUNC_APPEND     = 3'd0;
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FUNC_REMOVE     = 3'd2;
  localparam logic [2:0] FUNC_DUMP       = 3'd3;
  localparam logic [2:0] FUNC_CLEAR      = 3'd4;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_ENTRY = 2'd3
  } status_e;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_PUSH_FRONT,
    OP_REMOVE,
    OP_DUMP,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] entry_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
  } cmd_t;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

### design/dpd_front.sv
// Front end of the double-ended queue: decodes requests into commands
// and holds them in a two-entry command queue.
// Depends on dpd_pkg.
module dpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  dpd_pkg::in_item_t   in_item_i,
  output dpd_pkg::cmd_chan_t  cmd_o,
  input  logic                cmd_take_i
);

  dpd_pkg::cmd_t  dec_cmd;
  dpd_pkg::cmd_t  slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;
  logic           do_wr, do_rd;

  // Decode the operation code; unused codes become a no-op.
  always_comb begin
    dec_cmd.value = in_item_i.item_value;
    unique case (in_item_i.func)
      dpd_pkg::FUNC_APPEND:     dec_cmd.op = dpd_pkg::OP_APPEND;
      dpd_pkg::FUNC_PUSH_FRONT: dec_cmd.op = dpd_pkg::OP_PUSH_FRONT;
      dpd_pkg::FUNC_REMOVE:     dec_cmd.op = dpd_pkg::OP_REMOVE;
      dpd_pkg::FUNC_DUMP:       dec_cmd.op = dpd_pkg::OP_DUMP;
      dpd_pkg::FUNC_CLEAR:      dec_cmd.op = dpd_pkg::OP_CLEAR;
      default:                  dec_cmd.op = dpd_pkg::OP_NOP;
    endcase
  end

  assign full_o      = (fill_q == 2'd2);
  assign do_wr       = push_i && !full_o;
  assign do_rd       = cmd_take_i && (fill_q != 2'd0);
  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.cmd   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

### design/dpd_back.sv
// Back end of the double-ended queue: ring store, front pointer, count,
// dump sequencer and the result register.
// Depends on dpd_pkg.
module dpd_back #(
  parameter int DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpd_pkg::cmd_chan_t  cmd_i,
  output logic                cmd_take_o,
  output logic                empty_o,
  input  logic                pop_i,
  output dpd_pkg::out_item_t  out_item_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_DUMP
  } state_e;

  state_e              state_q, state_d;
  logic [PW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PW-1:0]       dump_ptr_q, dump_ptr_d;
  logic [CW-1:0]       remain_q, remain_d;
  logic                out_valid_q, out_valid_d;
  dpd_pkg::out_item_t  out_q, out_d;

  logic signed [31:0]  mem [DEPTH];
  logic signed [31:0]  rd_data_q;
  logic                wr_en, rd_en;
  logic [PW-1:0]       wr_addr, rd_addr;
  logic                out_free, is_full, is_empty;
  logic [SW-1:0]       back_sum;
  logic [PW-1:0]       back_addr, front_dec, front_inc, dump_inc;

  assign out_free = !out_valid_q || pop_i;
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Slot behind the last entry, and neighbors of the front, with ring wrap.
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign back_addr = (back_sum >= SW'(DEPTH)) ? PW'(back_sum - SW'(DEPTH)) : PW'(back_sum);
  assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
  assign dump_inc  = (dump_ptr_q == PW'(DEPTH - 1)) ? '0 : dump_ptr_q + PW'(1);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    dump_ptr_d  = dump_ptr_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    cmd_take_o  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = back_addr;
    rd_en       = 1'b0;
    rd_addr     = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid && out_free) begin
          cmd_take_o        = 1'b1;
          out_valid_d       = 1'b1;
          out_d.status      = dpd_pkg::STATUS_DONE;
          out_d.entry_value = '0;
          out_d.last        = 1'b1;
          unique case (cmd_i.cmd.op)
            dpd_pkg::OP_APPEND: begin
              if (is_full) begin
                out_d.status = dpd_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            dpd_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                out_d.status = dpd_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                front_d = front_dec;
                count_d = count_q + CW'(1);
              end
            end
            dpd_pkg::OP_REMOVE: begin
              if (is_empty) begin
                out_d.status = dpd_pkg::STATUS_EMPTY;
              end else begin
                // Result waits for the registered read.
                out_valid_d = out_valid_q && !pop_i;
                rd_en       = 1'b1;
                front_d     = front_inc;
                count_d     = count_q - CW'(1);
                state_d     = S_REMOVE;
              end
            end
            dpd_pkg::OP_DUMP: begin
              if (is_empty) begin
                out_d.status = dpd_pkg::STATUS_EMPTY;
              end else begin
                out_valid_d = out_valid_q && !pop_i;
                rd_en       = 1'b1;
                dump_ptr_d  = front_inc;
                remain_d    = count_q;
                state_d     = S_DUMP;
              end
            end
            dpd_pkg::OP_CLEAR: begin
              front_d = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_REMOVE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = dpd_pkg::STATUS_DONE;
          out_d.entry_value = rd_data_q;
          out_d.last        = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = dpd_pkg::STATUS_ENTRY;
          out_d.entry_value = rd_data_q;
          out_d.last        = (remain_q == CW'(1));
          if (remain_q == CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = dump_ptr_q;
            dump_ptr_d = dump_inc;
            remain_d   = remain_q - CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      dump_ptr_q  <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      dump_ptr_q  <= dump_ptr_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.cmd.value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

### design/deque_push_pop_dump_core.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
// Instantiates dpd_front and dpd_back; depends on dpd_pkg.
//
// Requests go in through a queue-style port (push/full) and results come
// out through one (empty/pop). A request is decoded into a two-entry
// command queue, so the requester can keep pushing while the back end
// works or while a result waits to be popped. The back end owns a ring
// of DEPTH entries with a front pointer and a count. Push back, push
// front, clear and unused codes each give one result. A remove goes
// through S_REMOVE, since the store read is registered. A dump of N
// entries streams one result per cycle while no result waits to be
// popped, last set on the final one; during it no command is started.
// A push on a full ring is dropped with status full; a remove or dump on
// an empty ring gives status empty. The store has no reset: only entries
// written since they became valid are ever read.
module deque_push_pop_dump_core #(
  parameter int DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request side
  input  logic                push,
  output logic                full,
  input  dpd_pkg::in_item_t   in_item_i,
  // Result side
  output logic                empty,
  input  logic                pop,
  output dpd_pkg::out_item_t  out_item_o
);

  dpd_pkg::cmd_chan_t cmd_chan;
  logic               cmd_take;

  // Decode and buffer requests.
  dpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .cmd_o      (cmd_chan),
    .cmd_take_i (cmd_take)
  );

  // Execute commands against the ring and hold the result register.
  dpd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_chan),
    .cmd_take_o (cmd_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
